[design/assert_macros.svh]
// Assertion macros used by the Kalman filter bank core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/skf_pkg.sv]
// Types, constants and register codes of the scalar Kalman filter bank.
package skf_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int CH_W         = 3;
    localparam int IDX_MAX_W    = 6;
    localparam int DATA_W       = 32;
    localparam int K_W          = 29;
    localparam int DIV_STEPS    = 29;
    localparam int DIV_CNT_W    = 5;
    localparam int CFG_IDX_W    = 3;

    // 1.0 in unsigned Q4.28 as a covariance and in unsigned Q1.28 as a gain.
    localparam logic [DATA_W-1:0] ONE_Q28 = 32'd268435456;
    localparam logic [K_W-1:0]    K_ONE   = 29'd268435456;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_Q_LINEAR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R_LINEAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q_ANGULAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R_ANGULAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Q_MOTION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R_MOTION  = 3'd5;

    // Register reset values.
    localparam logic [DATA_W-1:0] RST_Q_LINEAR  = 32'd26844;
    localparam logic [DATA_W-1:0] RST_R_LINEAR  = 32'd2684355;
    localparam logic [DATA_W-1:0] RST_Q_ANGULAR = 32'd134218;
    localparam logic [DATA_W-1:0] RST_R_ANGULAR = 32'd2147;
    localparam logic [DATA_W-1:0] RST_Q_MOTION  = 32'd26843546;
    localparam logic [DATA_W-1:0] RST_R_MOTION  = 32'd201326592;

    // Channel bounds of the noise pairs: the last linear channel and the motion channel.
    localparam logic [CH_W-1:0] CH_LINEAR_LAST = 3'd2;
    localparam logic [CH_W-1:0] CH_MOTION      = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PRED,
        S_DIV,
        S_MULX,
        S_MULP,
        S_WB,
        S_DONE
    } t_state;

    // Write into the state store.
    typedef struct packed {
        logic                 en;
        logic [IDX_MAX_W-1:0] idx;
        logic [DATA_W-1:0]    est;
        logic [DATA_W-1:0]    cov;
    } t_state_wr;

    // Status of the gain divider.
    typedef struct packed {
        logic           done;
        logic [K_W-1:0] k;
    } t_div_rsp;

endpackage

[design/skf_state_store.sv]
// Per-channel estimate and covariance memory with primed bits.
module skf_state_store #(
    parameter int CHANNELS = skf_pkg::CHANNELS_DEF,
    parameter int IDX_W    = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [skf_pkg::IDX_MAX_W-1:0]  i_rd_idx,
    input  skf_pkg::t_state_wr             i_wr,
    output logic                           o_primed,
    output logic [skf_pkg::DATA_W-1:0]     o_est,
    output logic [skf_pkg::DATA_W-1:0]     o_cov
);
    import skf_pkg::*;

    logic [2*DATA_W-1:0] mem [CHANNELS];
    logic [CHANNELS-1:0] r_primed;
    logic [2*DATA_W-1:0] r_rd_data;
    logic                r_rd_primed;

    // Synchronous memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.idx[IDX_W-1:0]] <= {i_wr.cov, i_wr.est};
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx[IDX_W-1:0]];
        end
    end

    // Primed bits double as valid bits for the memory entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= '0;
            r_rd_primed <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_primed[i_wr.idx[IDX_W-1:0]] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_primed <= r_primed[i_rd_idx[IDX_W-1:0]];
            end
        end
    end

    // An entry never written reads as the reset state.
    assign o_primed = r_rd_primed;
    assign o_est    = r_rd_primed ? r_rd_data[DATA_W-1:0] : '0;
    assign o_cov    = r_rd_primed ? r_rd_data[2*DATA_W-1:DATA_W] : ONE_Q28;

endmodule

[design/skf_div.sv]
// Serial restoring divider that forms the gain K = Ppred * 2^28 / (Ppred + R).
module skf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [skf_pkg::DATA_W-1:0]    i_ppred,
    input  logic [skf_pkg::DATA_W:0]      i_den,
    output skf_pkg::t_div_rsp             o_rsp
);
    import skf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W+1:0]    r_rem;
    logic [DATA_W:0]      r_den;
    logic [K_W-1:0]       r_quo;
    logic                 r_zero;
    logic [DATA_W+2:0]    w_trial;
    logic                 w_bit;
    logic [DATA_W+1:0]    w_rem_new;

    // Trial subtraction for one quotient bit.
    assign w_trial   = {1'b0, r_rem} - {2'b00, r_den};
    assign w_bit     = ~w_trial[DATA_W+2];
    assign w_rem_new = w_bit ? w_trial[DATA_W+1:0] : r_rem;

    // Control: busy while the DIV_STEPS quotient bits are formed, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: remainder starts at Ppred, the first bit is the 1.0 bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            r_rem  <= {1'b0, i_ppred, 1'b0} >> 1;
            r_den  <= i_den;
            r_quo  <= '0;
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_quo <= {r_quo[K_W-2:0], w_bit};
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_rem <= w_rem_new;
            end else begin
                r_rem <= {w_rem_new[DATA_W:0], 1'b0};
            end
        end
    end

    // A zero denominator gives a zero gain.
    assign o_rsp.done = r_done;
    assign o_rsp.k    = r_zero ? '0 : r_quo;

endmodule

[design/scalar_kalman_filter_bank_core.sv]
// Top level of the scalar Kalman filter bank: sequencer, update datapath, output register.
//
//  Channel   Dir  Bits                                              Request
//  s_axis    in   tdata: channel, measurement; tuser: invalid flag   one measurement
//  m_axis    out  tdata: channel, estimate, covariance; tuser: skip  one result
//  i_cfg     in   index, 32-bit data                                 one register write
//
//  A valid update on a primed channel is paced by the 29-step serial gain divider.
//  An invalid request, a first request on a channel or a channel beyond the bank
//  skips the divider. Reset is synchronous and active low; it clears the primed bits
//  and the registers at once, with no clearing pass. A stalled result waits in the
//  output register while the next request is taken and worked on.
`include "assert_macros.svh"

module scalar_kalman_filter_bank_core #(
    parameter int CHANNELS = skf_pkg::CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]       i_cfg_wdata,
    // Measurement stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [39:0]                      s_axis_tdata,  // channel[2:0], measurement[34:3]
    input  logic                             s_axis_tuser,  // measurement_invalid[0]
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [71:0]                      m_axis_tdata,  // out_channel[2:0],
                                                            // estimate[34:3],
                                                            // covariance[66:35]
    output logic                             m_axis_tuser   // skipped[0]
);
    import skf_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

    // Configuration registers.
    logic [DATA_W-1:0] r_q_lin, r_r_lin, r_q_ang, r_r_ang, r_q_mot, r_r_mot;

    // Sequencer and datapath registers.
    t_state                   r_state, n_state;
    logic [CH_W-1:0]          r_ch;
    logic signed [DATA_W-1:0] r_z;
    logic                     r_inv;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W:0]   r_diff;
    logic [DATA_W-1:0]        r_ppred;
    logic [DATA_W-1:0]        r_r;
    logic [K_W-1:0]           r_k;
    logic signed [62:0]       r_prod;
    logic [DATA_W-1:0]        r_res_est, r_res_cov;
    logic                     r_res_skip;

    // Output register.
    logic                     r_out_valid;
    logic [CH_W-1:0]          r_out_ch;
    logic [DATA_W-1:0]        r_out_est, r_out_cov;
    logic                     r_out_skip;

    // Combinational signals.
    logic                     w_accept;
    logic                     w_rd_en;
    logic [IDX_MAX_W-1:0]     w_rd_idx;
    logic [IDX_MAX_W-1:0]     w_cur_idx;
    t_state_wr                w_wr;
    logic                     w_primed;
    logic [DATA_W-1:0]        w_mem_est, w_mem_cov;
    logic                     w_in_bank;
    logic [DATA_W-1:0]        w_q, w_r;
    logic [DATA_W:0]          w_ppred_sum;
    logic [DATA_W-1:0]        w_ppred_sat;
    logic                     w_div_start;
    logic [DATA_W:0]          w_den;
    t_div_rsp                 w_div_rsp;
    logic signed [29:0]       w_mul_a;
    logic signed [DATA_W:0]   w_mul_b;
    logic signed [62:0]       w_prod;
    logic signed [62:0]       w_rnd;
    logic signed [35:0]       w_nx;
    logic [DATA_W-1:0]        w_nx_sat;
    logic [34:0]              w_pn;
    logic [DATA_W-1:0]        w_pn_sat;
    logic                     w_out_load;
    logic                     w_out_miss;

    // Configuration register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_lin <= RST_Q_LINEAR;
            r_r_lin <= RST_R_LINEAR;
            r_q_ang <= RST_Q_ANGULAR;
            r_r_ang <= RST_R_ANGULAR;
            r_q_mot <= RST_Q_MOTION;
            r_r_mot <= RST_R_MOTION;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_Q_LINEAR:  r_q_lin <= i_cfg_wdata;
                REG_R_LINEAR:  r_r_lin <= i_cfg_wdata;
                REG_Q_ANGULAR: r_q_ang <= i_cfg_wdata;
                REG_R_ANGULAR: r_r_ang <= i_cfg_wdata;
                REG_Q_MOTION:  r_q_mot <= i_cfg_wdata;
                REG_R_MOTION:  r_r_mot <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input handshake and memory read address.
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_rd_idx      = {{(IDX_MAX_W-CH_W){1'b0}}, s_axis_tdata[CH_W-1:0]};
    assign w_cur_idx     = {{(IDX_MAX_W-CH_W){1'b0}}, r_ch};
    assign w_in_bank     = {4'b0000, r_ch} < CH_LIMIT;

    // Noise pair for the current channel.
    always_comb begin
        if (r_ch <= CH_LINEAR_LAST) begin
            w_q = r_q_lin;
            w_r = r_r_lin;
        end else if (r_ch == CH_MOTION) begin
            w_q = r_q_mot;
            w_r = r_r_mot;
        end else begin
            w_q = r_q_ang;
            w_r = r_r_ang;
        end
    end

    // Predicted covariance, saturated to 32 bits, and the gain denominator.
    assign w_ppred_sum = {1'b0, w_mem_cov} + {1'b0, w_q};
    assign w_ppred_sat = w_ppred_sum[DATA_W] ? '1 : w_ppred_sum[DATA_W-1:0];
    assign w_den       = {1'b0, r_ppred} + {1'b0, r_r};

    // Shared multiplier: K * (z - x), then (1 - K) * Ppred.
    always_comb begin
        if (r_state == S_MULP) begin
            w_mul_a = {1'b0, K_ONE - r_k};
            w_mul_b = {1'b0, r_ppred};
        end else begin
            w_mul_a = {1'b0, r_k};
            w_mul_b = r_diff;
        end
    end
    assign w_prod = w_mul_a * w_mul_b;

    // Estimate correction, rounded half up and saturated.
    assign w_rnd = r_prod + 63'sd134217728;
    assign w_nx  = 36'(r_x) + 36'($signed(w_rnd[62:28]));
    always_comb begin
        if (w_nx[35:31] == 5'b00000 || w_nx[35:31] == 5'b11111) begin
            w_nx_sat = w_nx[DATA_W-1:0];
        end else if (w_nx[35]) begin
            w_nx_sat = 32'h8000_0000;
        end else begin
            w_nx_sat = 32'h7FFF_FFFF;
        end
    end

    // New covariance, rounded half up and saturated.
    assign w_pn     = w_rnd[62:28];
    assign w_pn_sat = (w_pn[34:32] != 3'b000) ? '1 : w_pn[DATA_W-1:0];

    assign w_out_load = !r_out_valid || m_axis_tready;

    // Next state, memory and divider control.
    always_comb begin
        n_state     = r_state;
        w_rd_en     = 1'b0;
        w_div_start = 1'b0;
        w_wr.en     = 1'b0;
        w_wr.idx    = w_cur_idx;
        w_wr.est    = r_z;
        w_wr.cov    = ONE_Q28;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_rd_en = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (!w_in_bank || r_inv) begin
                    n_state = S_DONE;
                end else if (!w_primed) begin
                    w_wr.en = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_PRED;
                end
            end
            S_PRED: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_MULX;
                end
            end
            S_MULX: n_state = S_MULP;
            S_MULP: n_state = S_WB;
            S_WB: begin
                w_wr.en  = 1'b1;
                w_wr.est = r_res_est;
                w_wr.cov = w_pn_sat;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers along the sequence.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_ch  <= s_axis_tdata[CH_W-1:0];
                    r_z   <= s_axis_tdata[CH_W+DATA_W-1:CH_W];
                    r_inv <= s_axis_tuser;
                end
            end
            S_READ: begin
                if (!w_in_bank) begin
                    r_res_est  <= '0;
                    r_res_cov  <= '0;
                    r_res_skip <= 1'b1;
                end else if (r_inv) begin
                    r_res_est  <= w_mem_est;
                    r_res_cov  <= w_mem_cov;
                    r_res_skip <= 1'b1;
                end else if (!w_primed) begin
                    r_res_est  <= r_z;
                    r_res_cov  <= ONE_Q28;
                    r_res_skip <= 1'b0;
                end
                r_ppred <= w_ppred_sat;
                r_r     <= w_r;
                r_x     <= w_mem_est;
                r_diff  <= 33'(r_z) - 33'($signed(w_mem_est));
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_k <= w_div_rsp.k;
                end
            end
            S_MULX: r_prod <= w_prod;
            S_MULP: begin
                r_res_est <= w_nx_sat;
                r_prod    <= w_prod;
            end
            S_WB: begin
                r_res_cov  <= w_pn_sat;
                r_res_skip <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Output register: filled from the finished result when free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_load) begin
            r_out_ch   <= r_ch;
            r_out_est  <= r_res_est;
            r_out_cov  <= r_res_cov;
            r_out_skip <= r_res_skip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out_cov, r_out_est, r_out_ch};
    assign m_axis_tuser  = r_out_skip;

    skf_state_store #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_rd_en),
        .i_rd_idx (w_rd_idx),
        .i_wr     (w_wr),
        .o_primed (w_primed),
        .o_est    (w_mem_est),
        .o_cov    (w_mem_cov)
    );

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_ppred (r_ppred),
        .i_den   (w_den),
        .o_rsp   (w_div_rsp)
    );

    // Checks on the sequencer and the result path.
    assign w_out_miss = r_out_valid && ({4'b0000, r_out_ch} >= CH_LIMIT);

    `SKF_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, w_div_rsp.done, r_state == S_DIV, "gain ready outside the divide state")
    `SKF_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, w_accept, r_state == S_READ, "accepted request did not start a read")
    `SKF_ASSERT_NOW(a_wr_in_update, i_clk, i_rst_n, w_wr.en, r_state == S_READ || r_state == S_WB, "state write outside an update")
    `SKF_ASSERT_NOW(a_bank_miss_zero, i_clk, i_rst_n, w_out_miss, r_out_skip && r_out_cov == '0 && r_out_est == '0, "channel beyond bank gave nonzero result")

endmodule
